@@ rtl/lrct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrct_pkg
// Shared types, constants and helpers for the lazily advanced timer block.
// ----------------------------------------------------------------------------
package lrct_pkg;

    // Field widths
    localparam int DATA_W   = 16;
    localparam int TIME_W   = 64;
    localparam int TIDX_W   = 2;
    localparam int REM_W    = 4;
    localparam int STEP11_W = 20;

    localparam int DEFAULT_TIMERS = 3;

    // Tick divider and its inverse modulo 2^16 (11 * 35747 = 6 * 2^16 + 1)
    localparam logic [REM_W-1:0]  TICK_DIV = 4'd11;
    localparam logic [DATA_W-1:0] INV11    = 16'd35747;

    // Mode word bits
    localparam logic [DATA_W-1:0] MODE_IRQ_MASK  = 16'h0030;
    localparam logic [DATA_W-1:0] MODE_IRQ_TARG  = 16'h0010;
    localparam logic [DATA_W-1:0] MODE_IRQ_FFFF  = 16'h0020;
    localparam logic [DATA_W-1:0] MODE_HIT_TARG  = 16'h0800;
    localparam logic [DATA_W-1:0] MODE_HIT_FFFF  = 16'h1000;
    localparam logic [DATA_W-1:0] MODE_UPDATED   = 16'h0400;
    localparam logic [DATA_W-1:0] MODE_HIT_MASK  = 16'h1800;
    localparam logic [DATA_W-1:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_COUNT  = 2'd0,
        REG_MODE   = 2'd1,
        REG_TARGET = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg_sel;

    // One bus access
    typedef struct packed {
        t_op               op;
        logic [TIDX_W-1:0] timer_index;
        t_reg_sel          reg_select;
        logic [DATA_W-1:0] write_data;
        logic [TIME_W-1:0] access_time;
    } t_item;

    // Timer state after the access, plus read value
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] mode;
        logic [DATA_W-1:0] target;
        logic [TIME_W-1:0] last;
    } t_snap;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              event_valid;
        logic [TIME_W-1:0] event_time;
    } t_result;

    // 11 * x by shift and add
    function automatic logic [STEP11_W-1:0] mul11(input logic [DATA_W-1:0] x);
        logic [STEP11_W-1:0] xe;
        xe = STEP11_W'(x);
        return (xe << 3) + (xe << 1) + xe;
    endfunction

endpackage

@@ rtl/lrct_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrct_in_if / lrct_out_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface lrct_in_if
    import lrct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIDX_W-1:0] timer_index;
    logic [1:0]        reg_select;
    logic [DATA_W-1:0] write_data;
    logic [TIME_W-1:0] access_time;

    modport source (
        output valid, op, timer_index, reg_select, write_data, access_time,
        input  ready
    );
    modport sink (
        input  valid, op, timer_index, reg_select, write_data, access_time,
        output ready
    );
endinterface

interface lrct_out_if
    import lrct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              event_valid;
    logic [TIME_W-1:0] event_time;

    modport source (
        output valid, read_data, event_valid, event_time,
        input  ready
    );
    modport sink (
        input  valid, read_data, event_valid, event_time,
        output ready
    );
endinterface

@@ rtl/lrct_rem11.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrct_rem11
// Remainder of a 64-bit timestamp modulo 11.
// ----------------------------------------------------------------------------
module lrct_rem11
    import lrct_pkg::*;
(
    input  logic [TIME_W-1:0] i_value,
    output logic [REM_W-1:0]  o_rem
);
    // 2^10 = 1 mod 11: fold 10-bit chunks
    logic [12:0] w_sum;
    logic [10:0] w_fold;
    logic [18:0] w_prod;
    logic [7:0]  w_quot;
    logic [10:0] w_sub;
    logic [10:0] w_r;

    assign w_sum = 13'(i_value[9:0])   + 13'(i_value[19:10]) + 13'(i_value[29:20])
                 + 13'(i_value[39:30]) + 13'(i_value[49:40]) + 13'(i_value[59:50])
                 + 13'(i_value[63:60]);
    assign w_fold = 11'(w_sum[9:0]) + 11'(w_sum[12:10]);

    // Quotient estimate 186/2048 is low by at most one; fix with one subtract
    assign w_prod = 19'(w_fold) * 19'(186);
    assign w_quot = w_prod[18:11];
    assign w_r    = w_fold - 11'(STEP11_W'(mul11(DATA_W'(w_quot))));
    assign w_sub  = w_r - 11'(TICK_DIV);
    assign o_rem  = (w_r >= 11'(TICK_DIV)) ? w_sub[REM_W-1:0] : w_r[REM_W-1:0];
endmodule

@@ rtl/lrct_timer_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrct_timer_bank
// Per-timer registers; brings the accessed timer up to date and applies
// the register access in a single step.
// ----------------------------------------------------------------------------
module lrct_timer_bank
    import lrct_pkg::*;
#(
    parameter int TIMERS = DEFAULT_TIMERS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  logic [REM_W-1:0] i_rem,
    input  logic             i_commit,
    output t_snap            o_snap
);
    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic [DATA_W-1:0] r_cnt  [TIMERS];
    logic [DATA_W-1:0] r_mode [TIMERS];
    logic [DATA_W-1:0] r_tgt  [TIMERS];
    logic [TIME_W-1:0] r_last [TIMERS];

    logic              w_hit;
    logic [IDX_W-1:0]  w_idx;
    logic [DATA_W-1:0] w_cnt, w_mode, w_tgt;
    logic [TIME_W-1:0] w_last, w_delta;
    logic              w_back;
    logic [DATA_W-1:0] w_st, w_sf;
    logic              w_ge_t, w_ge_f;
    logic [DATA_W-1:0] w_base;
    logic [31:0]       w_prod;
    logic [DATA_W-1:0] w_ticks;
    logic [DATA_W-1:0] w_cnt_a, w_mode_a;
    logic [TIME_W-1:0] w_last_a;
    logic [DATA_W-1:0] n_cnt, n_mode, n_tgt, n_rd;

    assign w_hit = (32'(i_item.timer_index) < TIMERS) && (i_item.reg_select != REG_UNUSED);
    assign w_idx = w_hit ? IDX_W'(i_item.timer_index) : '0;

    assign w_cnt  = r_cnt[w_idx];
    assign w_mode = r_mode[w_idx];
    assign w_tgt  = r_tgt[w_idx];
    assign w_last = r_last[w_idx];

    // Elapsed time; last update time is always a multiple of 11
    assign w_delta = i_item.access_time - w_last;
    assign w_back  = i_item.access_time < w_last;

    assign w_st = w_tgt - w_cnt;
    assign w_sf = COUNT_MAX - w_cnt;

    // ticks >= steps  <=>  delta >= 11 * steps
    assign w_ge_t = (|w_delta[TIME_W-1:STEP11_W]) || (w_delta[STEP11_W-1:0] >= mul11(w_st));
    assign w_ge_f = (|w_delta[TIME_W-1:STEP11_W]) || (w_delta[STEP11_W-1:0] >= mul11(w_sf));

    // Low 16 bits of the tick count: exact division by odd 11 via its inverse
    assign w_base  = w_delta[DATA_W-1:0] - DATA_W'(i_rem);
    assign w_prod  = w_base * INV11;
    assign w_ticks = w_prod[DATA_W-1:0];

    // Advance
    always_comb begin
        if (w_back) begin
            w_cnt_a  = w_cnt;
            w_mode_a = w_mode;
            w_last_a = w_last;
        end else begin
            w_cnt_a  = w_cnt + w_ticks;
            w_mode_a = w_mode | MODE_UPDATED | (w_ge_t ? MODE_HIT_TARG : '0)
                     | (w_ge_f ? MODE_HIT_FFFF : '0);
            w_last_a = i_item.access_time - TIME_W'(i_rem);
        end
    end

    // Register access
    always_comb begin
        n_cnt  = w_cnt_a;
        n_mode = w_mode_a;
        n_tgt  = w_tgt;
        n_rd   = '0;
        if (i_item.op == OP_WRITE) begin
            case (i_item.reg_select)
                REG_COUNT:  n_cnt  = i_item.write_data;
                REG_MODE:   n_mode = i_item.write_data;
                REG_TARGET: n_tgt  = i_item.write_data;
                default:    n_rd   = '0;
            endcase
        end else begin
            case (i_item.reg_select)
                REG_COUNT:  n_rd = w_cnt_a;
                REG_MODE: begin
                    n_rd   = w_mode_a;
                    n_mode = w_mode_a & ~MODE_HIT_MASK;
                end
                REG_TARGET: n_rd = w_tgt;
                default:    n_rd = '0;
            endcase
        end
    end

    always_comb begin
        o_snap.hit       = w_hit;
        o_snap.read_data = w_hit ? n_rd : '0;
        o_snap.count     = n_cnt;
        o_snap.mode      = n_mode;
        o_snap.target    = n_tgt;
        o_snap.last      = w_last_a;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMERS; i++) begin
                r_cnt[i]  <= '0;
                r_mode[i] <= '0;
                r_tgt[i]  <= '0;
                r_last[i] <= '0;
            end
        end else if (i_commit && w_hit) begin
            r_cnt[w_idx]  <= n_cnt;
            r_mode[w_idx] <= n_mode;
            r_tgt[w_idx]  <= n_tgt;
            r_last[w_idx] <= w_last_a;
        end
    end
endmodule

@@ rtl/lrct_predict.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrct_predict
// Earliest enabled interrupt deadline (target or FFFF) of the updated timer.
// ----------------------------------------------------------------------------
module lrct_predict
    import lrct_pkg::*;
(
    input  t_snap   i_snap,
    output t_result o_result
);
    logic [DATA_W-1:0] w_st, w_sf;
    logic [TIME_W-1:0] w_ct, w_cf;
    logic              w_en_t, w_en_f;

    assign w_st   = i_snap.target - i_snap.count;
    assign w_sf   = COUNT_MAX - i_snap.count;
    assign w_ct   = i_snap.last + TIME_W'(mul11(w_st));
    assign w_cf   = i_snap.last + TIME_W'(mul11(w_sf));
    assign w_en_t = i_snap.hit && (|(i_snap.mode & MODE_IRQ_TARG));
    assign w_en_f = i_snap.hit && (|(i_snap.mode & MODE_IRQ_FFFF));

    always_comb begin
        o_result.read_data   = i_snap.read_data;
        o_result.event_valid = i_snap.hit && (|(i_snap.mode & MODE_IRQ_MASK));
        if (w_en_t && w_en_f) begin
            o_result.event_time = (w_cf < w_ct) ? w_cf : w_ct;
        end else if (w_en_t) begin
            o_result.event_time = w_ct;
        end else if (w_en_f) begin
            o_result.event_time = w_cf;
        end else begin
            o_result.event_time = '0;
        end
    end
endmodule

@@ rtl/lazy_root_counter_timers_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_root_counter_timers_top
// Bank of lazily advanced 16-bit timers behind a valid/ready access port.
// ----------------------------------------------------------------------------
// Each bus access transfer produces exactly one result transfer. The block
// takes one access per clock and returns its result four register stages
// later (input register, timestamp remainder mod 11, timer update, deadline
// prediction then output register); a full pipeline stalls only when the
// result is not taken. Back-to-back accesses to the same timer are exact
// because the timer registers are read and written in the same stage.
// Out-of-range timers and register slot 3 return all-zero results.
module lazy_root_counter_timers_top
    import lrct_pkg::*;
#(
    parameter int TIMERS = DEFAULT_TIMERS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lrct_in_if.sink    i_in,
    lrct_out_if.source o_out
);
    logic             r_v1, r_v2, r_v3, r_vo;
    t_item            r_s1, r_s2;
    logic [REM_W-1:0] r_rem;
    t_snap            r_s3;
    t_result          r_out;

    logic             w_rdy1, w_rdy2, w_rdy3, w_rdyo;
    logic [REM_W-1:0] n_rem;
    t_snap            n_snap;
    t_result          n_out;

    // Per-stage ready: a stage loads when empty or when it moves on
    assign w_rdyo     = !r_vo || o_out.ready;
    assign w_rdy3     = !r_v3 || w_rdyo;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in.valid) begin
            r_s1.op          <= t_op'(i_in.op);
            r_s1.timer_index <= i_in.timer_index;
            r_s1.reg_select  <= t_reg_sel'(i_in.reg_select);
            r_s1.write_data  <= i_in.write_data;
            r_s1.access_time <= i_in.access_time;
        end
    end

    // Stage 2: timestamp remainder
    lrct_rem11 u_rem11 (
        .i_value (r_s1.access_time),
        .o_rem   (n_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_s2  <= r_s1;
            r_rem <= n_rem;
        end
    end

    // Stage 3: timer update and register access
    lrct_timer_bank #(
        .TIMERS (TIMERS)
    ) u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_s2),
        .i_rem    (r_rem),
        .i_commit (r_v2 && w_rdy3),
        .o_snap   (n_snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_s3 <= n_snap;
        end
    end

    // Stage 4: deadline prediction into the output register
    lrct_predict u_predict (
        .i_snap   (r_s3),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_rdyo) begin
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdyo && r_v3) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_vo;
    assign o_out.read_data   = r_out.read_data;
    assign o_out.event_valid = r_out.event_valid;
    assign o_out.event_time  = r_out.event_time;

`ifndef SYNTH
    // An accepted access always lands in the input stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted access lost at input stage");

    // A result with no deadline carries a zero deadline
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.event_valid) |-> (o_out.event_time == '0))
        else $error("deadline set without event");

    // Remainder stage output is always below the divider
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_rem < TICK_DIV))
        else $error("timestamp remainder out of range");
`endif
endmodule

@@ dv/lazy_root_counter_timers_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_root_counter_timers_top_tb
// Self-checking testbench for the lazily advanced timer bank. Bus accesses go
// in on a valid/ready channel. A behavioral timer model in the testbench
// predicts the read value and the interrupt deadline of each access. Each
// result transfer is compared field by field with the oldest prediction.
// Directed cases come first, then a receiver hold-off, then random traffic.
// ----------------------------------------------------------------------------
module lazy_root_counter_timers_top_tb;
    import lrct_pkg::*;

    localparam int          NUM_TIMERS   = DEFAULT_TIMERS;
    localparam int          RANDOM_ITEMS = 650;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          MAX_CYCLES   = 400000;
    localparam logic [7:0]  RX_PATTERN   = 8'b1011_0110;
    localparam logic [TIME_W-1:0] TICK   = TIME_W'(TICK_DIV);
    localparam logic [TIME_W-1:0] T_MAX  = '1;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;

    lrct_in_if  in_ch ();
    lrct_out_if out_ch ();

    lazy_root_counter_timers_top #(
        .TIMERS (NUM_TIMERS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Timer model state
    logic [DATA_W-1:0] tmr_count  [NUM_TIMERS];
    logic [DATA_W-1:0] tmr_mode   [NUM_TIMERS];
    logic [DATA_W-1:0] tmr_target [NUM_TIMERS];
    logic [TIME_W-1:0] tmr_last   [NUM_TIMERS];

    t_result     pending_results[$];
    int unsigned mismatches;
    int unsigned live_accesses;
    int unsigned cycles;

    // Stimulus pacing
    logic        tx_bursty;
    int unsigned tx_burst_left;
    t_rx_style   rx_style;
    int unsigned rx_hold;

    // Running timestamp for generated sequences
    logic [TIME_W-1:0] ts_now;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Timer model: advance the accessed timer, apply the access, report the
    // earliest enabled deadline.
    // ------------------------------------------------------------------------
    function automatic t_result timer_access(input t_item a);
        t_result           r;
        int unsigned       t;
        logic [TIME_W-1:0] ticks;
        logic [TIME_W-1:0] dl_targ;
        logic [TIME_W-1:0] dl_ffff;
        logic [DATA_W-1:0] to_targ;
        logic [DATA_W-1:0] to_ffff;
        r = '0;
        t = 32'(a.timer_index);
        if (t >= NUM_TIMERS || a.reg_select == REG_UNUSED) begin
            return r;
        end

        // lazy catch-up, skipped when time runs backwards
        if (a.access_time >= tmr_last[t]) begin
            ticks   = (a.access_time - tmr_last[t]) / TICK;
            to_targ = tmr_target[t] - tmr_count[t];
            to_ffff = COUNT_MAX - tmr_count[t];
            if (TIME_W'(to_targ) <= ticks) begin
                tmr_mode[t] = tmr_mode[t] | MODE_HIT_TARG;
            end
            if (TIME_W'(to_ffff) <= ticks) begin
                tmr_mode[t] = tmr_mode[t] | MODE_HIT_FFFF;
            end
            tmr_mode[t]  = tmr_mode[t] | MODE_UPDATED;
            tmr_count[t] = tmr_count[t] + ticks[DATA_W-1:0];
            tmr_last[t]  = tmr_last[t] + ticks * TICK;
        end

        // register access
        if (a.op == OP_WRITE) begin
            case (a.reg_select)
                REG_COUNT: tmr_count[t]  = a.write_data;
                REG_MODE:  tmr_mode[t]   = a.write_data;
                default:   tmr_target[t] = a.write_data;
            endcase
        end else begin
            case (a.reg_select)
                REG_COUNT: r.read_data = tmr_count[t];
                REG_MODE: begin
                    r.read_data = tmr_mode[t];
                    tmr_mode[t] = tmr_mode[t] & ~MODE_HIT_MASK;
                end
                default:   r.read_data = tmr_target[t];
            endcase
        end

        // deadline from the post-access state
        to_targ = tmr_target[t] - tmr_count[t];
        to_ffff = COUNT_MAX - tmr_count[t];
        dl_targ = tmr_last[t] + TICK * TIME_W'(to_targ);
        dl_ffff = tmr_last[t] + TICK * TIME_W'(to_ffff);
        if ((tmr_mode[t] & MODE_IRQ_TARG) != '0) begin
            r.event_valid = 1'b1;
            r.event_time  = dl_targ;
        end
        if ((tmr_mode[t] & MODE_IRQ_FFFF) != '0) begin
            if (!r.event_valid || dl_ffff < r.event_time) begin
                r.event_time = dl_ffff;
            end
            r.event_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic t_item make_item(input t_op op, input int unsigned t,
                                        input t_reg_sel rs,
                                        input logic [DATA_W-1:0] d,
                                        input logic [TIME_W-1:0] at);
        t_item a;
        a.op          = op;
        a.timer_index = TIDX_W'(t);
        a.reg_select  = rs;
        a.write_data  = d;
        a.access_time = at;
        return a;
    endfunction

    // Fully random access, out-of-range timer and unused slot included
    function automatic t_item noise_item();
        return make_item(t_op'($urandom_range(0, 1)), $urandom_range(0, 3),
                         t_reg_sel'($urandom_range(0, 3)), DATA_W'($urandom),
                         {$urandom, $urandom});
    endfunction

    // Time step between accesses: mostly short, some past a counter wrap
    function automatic logic [TIME_W-1:0] time_step();
        logic [TIME_W-1:0] jump;
        int unsigned       pick;
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            return '0;
        end else if (pick < 16) begin
            return TIME_W'($urandom_range(1, 500));
        end else if (pick < 19) begin
            return TIME_W'($urandom_range(500, 800000));
        end
        jump = {$urandom, $urandom};
        return jump >> $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: in bursty mode, bursts with random gaps; one transfer per call
    // ------------------------------------------------------------------------
    task automatic send_access(input t_item a);
        int unsigned gap;
        if (tx_bursty && tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap           = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= a.op;
        in_ch.timer_index <= a.timer_index;
        in_ch.reg_select  <= a.reg_select;
        in_ch.write_data  <= a.write_data;
        in_ch.access_time <= a.access_time;
        // ready is stable between the falling edge and the next rising edge
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        if (a.timer_index < NUM_TIMERS && a.reg_select != REG_UNUSED) begin
            live_accesses++;
        end
        pending_results.push_back(timer_access(a));
    endtask

    // Sender pause until every expected result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Programs a timer, then runs reads and writes at advancing times
    task automatic run_sequence();
        int unsigned       t;
        int unsigned       n;
        logic [DATA_W-1:0] base;
        logic [TIME_W-1:0] seq_now;
        t_reg_sel          rs;
        t_op               op;
        t       = $urandom_range(0, NUM_TIMERS - 1);
        seq_now = ts_now;
        if (tmr_last[t] > ts_now && $urandom_range(0, 3) != 0) begin
            seq_now = tmr_last[t];
        end
        base = ($urandom_range(0, 3) == 0) ? COUNT_MAX - DATA_W'($urandom_range(0, 300))
                                           : DATA_W'($urandom);
        send_access(make_item(OP_WRITE, t, REG_COUNT, base, seq_now));
        seq_now += time_step();
        send_access(make_item(OP_WRITE, t, REG_TARGET,
                              base + DATA_W'($urandom_range(0, 400)), seq_now));
        seq_now += time_step();
        send_access(make_item(OP_WRITE, t, REG_MODE, DATA_W'($urandom), seq_now));
        n = $urandom_range(2, 7);
        repeat (n) begin
            seq_now += time_step();
            rs = t_reg_sel'($urandom_range(0, 2));
            op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_READ;
            send_access(make_item(op, t, rs, DATA_W'($urandom), seq_now));
        end
        if (seq_now > ts_now && seq_now - ts_now < 64'h1_0000_0000) begin
            ts_now = seq_now;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        tx_bursty = 1'b0;
        rx_style  = RX_STEADY;
        // equal time at reset: counter equals target
        send_access(make_item(OP_READ,  0, REG_COUNT,  '0,       '0));
        send_access(make_item(OP_READ,  0, REG_MODE,   '0,       '0));
        send_access(make_item(OP_WRITE, 0, REG_TARGET, 16'h0005, 64'd11));
        send_access(make_item(OP_WRITE, 0, REG_MODE,   16'h0030, 64'd20));
        send_access(make_item(OP_READ,  0, REG_COUNT,  '0,       64'd88));
        send_access(make_item(OP_READ,  0, REG_MODE,   '0,       64'd88));
        // time going backwards
        send_access(make_item(OP_READ,  0, REG_COUNT,  '0,       64'd40));
        send_access(make_item(OP_WRITE, 0, REG_TARGET, 16'hFFFF, 64'd40));
        // unused slot and out-of-range timer
        send_access(make_item(OP_READ,  0, REG_UNUSED, '0,       64'd100));
        send_access(make_item(OP_WRITE, 0, REG_UNUSED, 16'hFFFF, 64'd100));
        send_access(make_item(OP_READ,  3, REG_COUNT,  '0,       64'd100));
        send_access(make_item(OP_WRITE, 3, REG_MODE,   16'hFFFF, T_MAX));
        // counter wrap past FFFF with every mode bit set
        send_access(make_item(OP_WRITE, 1, REG_COUNT,  16'hFFFF, 64'd1000));
        send_access(make_item(OP_WRITE, 1, REG_TARGET, 16'h0000, 64'd1000));
        send_access(make_item(OP_WRITE, 1, REG_MODE,   16'hFFFF, 64'd1000));
        send_access(make_item(OP_READ,  1, REG_MODE,   '0,       64'd1011));
        send_access(make_item(OP_WRITE, 1, REG_MODE,   16'h0010, 64'd2000));
        send_access(make_item(OP_READ,  1, REG_TARGET, '0,       64'd2000));
        send_access(make_item(OP_WRITE, 1, REG_MODE,   16'h0000, 64'd3000));
        // top of the timestamp range; deadline wraps
        send_access(make_item(OP_WRITE, 2, REG_MODE,   16'h0020, '0));
        send_access(make_item(OP_READ,  2, REG_COUNT,  '0,       T_MAX));
        send_access(make_item(OP_WRITE, 2, REG_COUNT,  16'h0000, T_MAX));
        send_access(make_item(OP_READ,  2, REG_MODE,   '0,       T_MAX));
        send_access(make_item(OP_WRITE, 2, REG_MODE,   16'h0000, T_MAX));
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering transfers
    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_style  = RX_RANDOM;
        rx_hold   = LONG_HOLD;
        repeat (6) run_sequence();
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned n;
        while (live_accesses < RANDOM_ITEMS) begin
            // new pacing before about one segment in eight
            if ($urandom_range(0, 7) == 0) begin
                tx_bursty = 1'($urandom_range(0, 1));
                rx_style  = t_rx_style'($urandom_range(0, 2));
            end
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) send_access(noise_item());
            end else begin
                run_sequence();
            end
            if ($urandom_range(0, 40) == 0) begin
                drain_results();
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready pattern, with a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_receiver
        int unsigned phase;
        phase = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (rx_hold > 0) begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_STEADY:   out_ch.ready <= 1'b1;
                    RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default:     out_ch.ready <= RX_PATTERN[phase % 8];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: sampled mid-cycle, transfer lands at the next edge
    // ------------------------------------------------------------------------
    initial begin : result_checker
        t_result want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: read_data %h",
                           out_ch.read_data);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, out_ch.read_data);
                        mismatches++;
                    end
                    if (out_ch.event_valid !== want.event_valid) begin
                        $error("event_valid: expected %b, got %b",
                               want.event_valid, out_ch.event_valid);
                        mismatches++;
                    end
                    if (out_ch.event_time !== want.event_time) begin
                        $error("event_time: expected %h, got %h",
                               want.event_time, out_ch.event_time);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cycles        = 0;
        mismatches    = 0;
        live_accesses = 0;
        tx_bursty     = 1'b0;
        tx_burst_left = 0;
        rx_style      = RX_STEADY;
        rx_hold       = 0;
        ts_now        = 64'd4000;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_count[i]  = '0;
            tmr_mode[i]   = '0;
            tmr_target[i] = '0;
            tmr_last[i]   = '0;
        end
        i_rst_n            = 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_READ;
        in_ch.timer_index <= '0;
        in_ch.reg_select  <= REG_COUNT;
        in_ch.write_data  <= '0;
        in_ch.access_time <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_traffic();

        // wait out the pipeline, then catch any stray results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
